FILE: rtl/ubbs_pkg.sv
package ubbs_pkg;

	// Field widths
	localparam int CLK_W  = 28;
	localparam int BAUD_W = 24;
	localparam int DIV_W  = 16;
	localparam int IDLE_W = 9;

	// Configuration register indexes
	localparam logic [2:0] REG_HOST_WINDOW   = 3'd0;
	localparam logic [2:0] REG_DEVICE_WINDOW = 3'd1;
	localparam logic [2:0] REG_FAST_CLOCK    = 3'd2;
	localparam logic [2:0] REG_SLOW_CLOCK    = 3'd3;
	localparam logic [2:0] REG_DEFAULT_BAUD  = 3'd4;

	// Reset values of the configuration registers
	localparam logic [7:0]        RST_HOST_WINDOW   = 8'd5;
	localparam logic [7:0]        RST_DEVICE_WINDOW = 8'd3;
	localparam logic [CLK_W-1:0]  RST_FAST_CLOCK    = 28'd84000000;
	localparam logic [CLK_W-1:0]  RST_SLOW_CLOCK    = 28'd42000000;
	localparam logic [BAUD_W-1:0] RST_DEFAULT_BAUD  = 24'd115200;

	// Input command codes
	localparam logic [1:0] CMD_HOST   = 2'd0;
	localparam logic [1:0] CMD_DEVICE = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// Frame bytes
	localparam logic [7:0] BYTE_END     = 8'hC0;
	localparam logic [7:0] BYTE_APPLY   = 8'h0F;
	localparam logic [7:0] BYTE_RESTORE = 8'h12;

	// Host frame positions
	localparam logic [4:0] HOST_LEN     = 5'd18;
	localparam logic [4:0] HOST_LAST    = 5'd17;
	localparam logic [4:0] HOST_BAUD_B0 = 5'd9;
	localparam logic [4:0] HOST_BAUD_B1 = 5'd10;
	localparam logic [4:0] HOST_BAUD_B2 = 5'd11;

	// Device frame positions
	localparam logic [3:0] DEV_LEN  = 4'd11;
	localparam logic [3:0] DEV_LAST = 4'd10;
	localparam logic [3:0] DEV_CMD  = 4'd1;

	localparam logic [IDLE_W-1:0] IDLE_MAX = 9'd511;

	// Divider iterations: one quotient bit per cycle
	localparam logic [4:0] DIV_LAST = 5'(CLK_W - 1);

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic              action;
		logic [BAUD_W-1:0] baud_used;
		logic [DIV_W-1:0]  fast_uart_divisor;
		logic [DIV_W-1:0]  slow_uart_divisor;
		logic              saturated;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	// Expected byte at each fixed position of the host frame
	function automatic logic [7:0] host_pattern(logic [4:0] pos);
		logic [7:0] b;
		case (pos)
			5'd0:    b = 8'hC0;
			5'd2:    b = 8'h0F;
			5'd3:    b = 8'h08;
			5'd14:   b = 8'hC2;
			5'd15:   b = 8'h01;
			5'd17:   b = 8'hC0;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Expected byte at each fixed position of the device frame
	function automatic logic [7:0] dev_pattern(logic [3:0] pos);
		logic [7:0] b;
		case (pos)
			4'd0:    b = 8'h01;
			4'd2:    b = 8'h02;
			4'd10:   b = 8'hC0;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/uart_bridge_baud_snooper.sv
// Host, tick, unused-code and ordinary device beats finish in the cycle they are taken.
// A device closing beat that completes a valid frame shows its result after the fast and
// slow restoring divisions, which share one subtractor, and the load state.
// Throughput: one beat per cycle while idle; a closing device beat holds item_ready
// low until its result loads, longer while the result register is still full.
// Reset (arst_n low, asynchronous): matchers, window counters and captured baud clear,
// configuration registers return to their defaults, the result register is emptied.
module uart_bridge_baud_snooper
	import ubbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CLK_W-1:0]  cfg_data
);

	// Configuration
	logic [7:0]        host_window_q;
	logic [7:0]        device_window_q;
	logic [CLK_W-1:0]  fast_clock_q;
	logic [CLK_W-1:0]  slow_clock_q;
	logic [BAUD_W-1:0] default_baud_q;

	// Matcher state
	logic [4:0]        host_step_q, host_step_d;
	logic [3:0]        dev_step_q, dev_step_d;
	logic [IDLE_W-1:0] host_idle_q, host_idle_d;
	logic [IDLE_W-1:0] dev_idle_q, dev_idle_d;
	logic [BAUD_W-1:0] captured_q, captured_d;
	logic [BAUD_W-1:0] pending_q, pending_d;
	// device_command only ever holds zero, apply or restore: keep it as two bits
	logic              cmd_valid_q, cmd_valid_d;
	logic              cmd_restore_q, cmd_restore_d;
	logic              launch;

	// Sequencer and shared divider
	state_t            state_q;
	logic              phase_slow_q;
	logic [4:0]        div_cnt_q;
	logic [CLK_W-1:0]  dvd_q;
	logic [BAUD_W-1:0] rem_q;
	logic [BAUD_W-1:0] baud_q;
	logic              action_q;
	logic [DIV_W-1:0]  fast_div_q;
	logic              fast_clip_q;
	logic [DIV_W-1:0]  slow_div;
	logic              slow_clip;

	logic [BAUD_W:0]   rem_sh;
	logic [BAUD_W+1:0] diff;
	logic              q_bit;
	logic [CLK_W-1:0]  quo_nx;

	logic              beat;
	logic [7:0]        b;

	assign item_ready = (state_q == ST_IDLE);
	assign beat       = item_valid && item_ready;
	assign b          = item.data_byte;

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_window_q   <= RST_HOST_WINDOW;
			device_window_q <= RST_DEVICE_WINDOW;
			fast_clock_q    <= RST_FAST_CLOCK;
			slow_clock_q    <= RST_SLOW_CLOCK;
			default_baud_q  <= RST_DEFAULT_BAUD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOST_WINDOW:   host_window_q   <= cfg_data[7:0];
				REG_DEVICE_WINDOW: device_window_q <= cfg_data[7:0];
				REG_FAST_CLOCK:    fast_clock_q    <= cfg_data;
				REG_SLOW_CLOCK:    slow_clock_q    <= cfg_data;
				REG_DEFAULT_BAUD:  default_baud_q  <= cfg_data[BAUD_W-1:0];
				default: ;
			endcase
		end
	end

	// Host-side matcher: captures the baud bytes, latches pending baud on the closing byte.
	// Window expiry is checked first and restarts both the counter and the frame.
	always_comb begin
		host_step_d = host_step_q;
		host_idle_d = host_idle_q;
		captured_d  = captured_q;
		pending_d   = pending_q;
		if (beat && item.command == CMD_HOST) begin
			if (host_idle_d > {1'b0, host_window_q}) begin
				host_idle_d = '0;
				host_step_d = '0;
			end
			if (host_step_d >= HOST_LEN) begin
				host_step_d = '0;
			end
			case (host_step_d)
				HOST_BAUD_B0: begin
					captured_d  = {16'h0000, b};
					host_step_d = host_step_d + 5'd1;
				end
				HOST_BAUD_B1: begin
					captured_d  = captured_q + {8'h00, b, 8'h00};
					host_step_d = host_step_d + 5'd1;
				end
				HOST_BAUD_B2: begin
					captured_d  = captured_q + {b, 16'h0000};
					host_step_d = host_step_d + 5'd1;
				end
				HOST_LAST: begin
					// a wrong closing byte leaves the matcher waiting here
					if (b == BYTE_END) begin
						host_step_d = '0;
						pending_d   = captured_q;
					end
				end
				default: begin
					if (b == host_pattern(host_step_d)) begin
						host_step_d = host_step_d + 5'd1;
					end else begin
						host_step_d = '0;
					end
				end
			endcase
		end else if (beat && item.command == CMD_TICK) begin
			if (host_idle_q < IDLE_MAX) begin
				host_idle_d = host_idle_q + 9'd1;
			end
		end
	end

	// Device-side matcher: takes the command byte, launches the divider on the closing byte
	always_comb begin
		dev_step_d    = dev_step_q;
		dev_idle_d    = dev_idle_q;
		cmd_valid_d   = cmd_valid_q;
		cmd_restore_d = cmd_restore_q;
		launch        = 1'b0;
		if (beat && item.command == CMD_DEVICE) begin
			if (dev_idle_d > {1'b0, device_window_q}) begin
				dev_idle_d = '0;
				dev_step_d = '0;
			end
			if (dev_step_d >= DEV_LEN) begin
				dev_step_d = '0;
			end
			if (dev_step_d == DEV_CMD) begin
				if (b == BYTE_APPLY || b == BYTE_RESTORE) begin
					cmd_valid_d   = 1'b1;
					cmd_restore_d = (b == BYTE_RESTORE);
					dev_step_d    = dev_step_d + 4'd1;
				end else begin
					dev_step_d = '0;
				end
			end else if (dev_step_d != DEV_LAST) begin
				if (b == dev_pattern(dev_step_d)) begin
					dev_step_d = dev_step_d + 4'd1;
				end else begin
					dev_step_d = '0;
				end
			end else if (b == BYTE_END) begin
				dev_step_d = '0;
				// no command seen since reset: the frame completes silently
				launch     = cmd_valid_q;
			end
		end else if (beat && item.command == CMD_TICK) begin
			if (dev_idle_q < IDLE_MAX) begin
				dev_idle_d = dev_idle_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_step_q   <= '0;
			dev_step_q    <= '0;
			host_idle_q   <= '0;
			dev_idle_q    <= '0;
			captured_q    <= '0;
			pending_q     <= '0;
			cmd_valid_q   <= 1'b0;
			cmd_restore_q <= 1'b0;
		end else begin
			host_step_q   <= host_step_d;
			dev_step_q    <= dev_step_d;
			host_idle_q   <= host_idle_d;
			dev_idle_q    <= dev_idle_d;
			captured_q    <= captured_d;
			pending_q     <= pending_d;
			cmd_valid_q   <= cmd_valid_d;
			cmd_restore_q <= cmd_restore_d;
		end
	end

	// Shared restoring divider: one quotient bit per cycle, the quotient shifts in
	// behind the dividend. A zero baud never borrows, so the quotient comes out all
	// ones and clips, which gives 65535 with the saturation flag as required.
	assign rem_sh = {rem_q, dvd_q[CLK_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, baud_q};
	assign q_bit  = ~diff[BAUD_W+1];
	assign quo_nx = {dvd_q[CLK_W-2:0], q_bit};

	assign slow_clip = |quo_nx[CLK_W-1:DIV_W];
	assign slow_div  = slow_clip ? {DIV_W{1'b1}} : quo_nx[DIV_W-1:0];

	// Sequencer: idle, fast division then slow division, then load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_slow_q <= 1'b0;
			div_cnt_q    <= '0;
			result_valid <= 1'b0;
		end else begin
			// load a fresh beat once the register is free, else drop the taken one
			if (state_q == ST_LOAD && (!result_valid || result_ready)) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (launch) begin
						state_q      <= ST_DIV;
						phase_slow_q <= 1'b0;
						div_cnt_q    <= '0;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_LAST) begin
						div_cnt_q <= '0;
						if (phase_slow_q) begin
							state_q <= ST_LOAD;
						end else begin
							phase_slow_q <= 1'b1;
						end
					end else begin
						div_cnt_q <= div_cnt_q + 5'd1;
					end
				end
				ST_LOAD: begin
					// hold until the result register is free
					if (!result_valid || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (launch) begin
					baud_q   <= cmd_restore_q ? default_baud_q : pending_q;
					action_q <= cmd_restore_q;
					dvd_q    <= fast_clock_q;
					rem_q    <= '0;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST && !phase_slow_q) begin
					// fast quotient done: keep it, restart on the slow clock
					fast_div_q  <= slow_div;
					fast_clip_q <= slow_clip;
					dvd_q       <= slow_clock_q;
					rem_q       <= '0;
				end else begin
					dvd_q <= quo_nx;
					rem_q <= q_bit ? diff[BAUD_W-1:0] : rem_sh[BAUD_W-1:0];
				end
			end
			ST_LOAD: begin
				if (!result_valid || result_ready) begin
					result.action            <= action_q;
					result.baud_used         <= baud_q;
					result.fast_uart_divisor <= fast_div_q;
					result.slow_uart_divisor <= dvd_q[CLK_W-1:DIV_W] != '0 ?
						{DIV_W{1'b1}} : dvd_q[DIV_W-1:0];
					result.saturated         <= fast_clip_q || (dvd_q[CLK_W-1:DIV_W] != '0);
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/ubbs_checker.sv
module ubbs_assertions
	import ubbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  item_t             item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  result_t           result
);

	// A stalled result beat holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Only a device beat can start the divider; every other beat leaves the block ready
	a_short_beat: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.command != CMD_DEVICE |=> item_ready)
		else $error("non-device beat left the block busy");

	// A fresh result is loaded only while the block is busy
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result appeared without a division");

	// A zero baud always saturates
	a_zero_baud_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.saturated |-> result.baud_used != '0)
		else $error("zero baud without saturation flag");

endmodule

bind uart_bridge_baud_snooper ubbs_assertions u_ubbs_assertions (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

FILE: sim/ubbs_checker.sv
`timescale 1ns / 1ps

module ubbs_checker
	import ubbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  item_t            item,
	input  logic             result_valid,
	input  logic             result_ready,
	input  result_t          result,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CLK_W-1:0] cfg_data,
	output int               fail_count,
	output int               outstanding
);

	// Fixed bytes of both frames, position 0 in the low byte; wildcard slots hold zero
	localparam logic [17:0][7:0] HOST_BYTES = {
		8'hC0, 8'h00, 8'h01, 8'hC2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h0F, 8'h00, 8'hC0
	};
	localparam logic [10:0][7:0] DEV_BYTES = {
		8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01
	};

	logic [7:0]        host_window;
	logic [7:0]        dev_window;
	logic [CLK_W-1:0]  fast_hz;
	logic [CLK_W-1:0]  slow_hz;
	logic [BAUD_W-1:0] restore_baud;

	logic [4:0]        host_pos;
	logic [3:0]        dev_pos;
	logic [IDLE_W-1:0] host_ms;
	logic [IDLE_W-1:0] dev_ms;
	logic [BAUD_W-1:0] baud_rx;
	logic [BAUD_W-1:0] baud_latched;
	logic [7:0]        dev_cmd;

	result_t due_divisors[$];
	int      mismatches;

	// {clipped, divisor}
	function automatic logic [DIV_W:0] clock_divisor(logic [CLK_W-1:0] hz, logic [BAUD_W-1:0] baud);
		logic [CLK_W-1:0] q;
		if (baud == '0)
			return {1'b1, 16'hFFFF};
		q = hz / baud;
		if (q > 28'hFFFF)
			return {1'b1, 16'hFFFF};
		return {1'b0, q[DIV_W-1:0]};
	endfunction

	task automatic queue_divisors(input logic act, input logic [BAUD_W-1:0] baud);
		logic [DIV_W:0] f;
		logic [DIV_W:0] s;
		result_t r;
		f = clock_divisor(fast_hz, baud);
		s = clock_divisor(slow_hz, baud);
		r.action            = act;
		r.baud_used         = baud;
		r.fast_uart_divisor = f[DIV_W-1:0];
		r.slow_uart_divisor = s[DIV_W-1:0];
		r.saturated         = f[DIV_W] | s[DIV_W];
		due_divisors.push_back(r);
	endtask

	task automatic snoop_host(input logic [7:0] b);
		if (host_ms > host_window) begin
			host_ms  = '0;
			host_pos = '0;
		end
		if (host_pos >= HOST_LEN)
			host_pos = '0;
		if (host_pos == HOST_BAUD_B0) begin
			baud_rx  = {16'd0, b};
			host_pos = host_pos + 1'b1;
		end else if (host_pos == HOST_BAUD_B1) begin
			baud_rx  = baud_rx + {8'd0, b, 8'd0};
			host_pos = host_pos + 1'b1;
		end else if (host_pos == HOST_BAUD_B2) begin
			baud_rx  = baud_rx + {b, 16'd0};
			host_pos = host_pos + 1'b1;
		end else if (host_pos == HOST_LAST) begin
			// wrong closing byte keeps waiting here
			if (b == BYTE_END) begin
				host_pos     = '0;
				baud_latched = baud_rx;
			end
		end else if (b == HOST_BYTES[host_pos]) begin
			host_pos = host_pos + 1'b1;
		end else begin
			host_pos = '0;
		end
	endtask

	task automatic snoop_device(input logic [7:0] b);
		if (dev_ms > dev_window) begin
			dev_ms  = '0;
			dev_pos = '0;
		end
		if (dev_pos >= DEV_LEN)
			dev_pos = '0;
		if (dev_pos == DEV_CMD) begin
			if (b == BYTE_APPLY || b == BYTE_RESTORE) begin
				dev_cmd = b;
				dev_pos = dev_pos + 1'b1;
			end else begin
				dev_pos = '0;
			end
		end else if (dev_pos != DEV_LAST) begin
			if (b == DEV_BYTES[dev_pos])
				dev_pos = dev_pos + 1'b1;
			else
				dev_pos = '0;
		end else if (b == BYTE_END) begin
			dev_pos = '0;
			if (dev_cmd == BYTE_APPLY)
				queue_divisors(1'b0, baud_latched);
			else if (dev_cmd == BYTE_RESTORE)
				queue_divisors(1'b1, restore_baud);
		end
	endtask

	task automatic report(input string field, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			host_window  = RST_HOST_WINDOW;
			dev_window   = RST_DEVICE_WINDOW;
			fast_hz      = RST_FAST_CLOCK;
			slow_hz      = RST_SLOW_CLOCK;
			restore_baud = RST_DEFAULT_BAUD;
			host_pos     = '0;
			dev_pos      = '0;
			host_ms      = '0;
			dev_ms       = '0;
			baud_rx      = '0;
			baud_latched = '0;
			dev_cmd      = '0;
			due_divisors.delete();
			mismatches   = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (due_divisors.size() == 0) begin
					$display("%0t: result beat with none expected, got 0x%0h", $time, result);
					mismatches++;
				end else begin
					want = due_divisors.pop_front();
					report("action", want.action, result.action);
					report("baud_used", want.baud_used, result.baud_used);
					report("fast_uart_divisor", want.fast_uart_divisor,
						result.fast_uart_divisor);
					report("slow_uart_divisor", want.slow_uart_divisor,
						result.slow_uart_divisor);
					report("saturated", want.saturated, result.saturated);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_HOST_WINDOW:   host_window  = cfg_data[7:0];
					REG_DEVICE_WINDOW: dev_window   = cfg_data[7:0];
					REG_FAST_CLOCK:    fast_hz      = cfg_data;
					REG_SLOW_CLOCK:    slow_hz      = cfg_data;
					REG_DEFAULT_BAUD:  restore_baud = cfg_data[BAUD_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				case (item.command)
					CMD_HOST:   snoop_host(item.data_byte);
					CMD_DEVICE: snoop_device(item.data_byte);
					CMD_TICK: begin
						if (host_ms < IDLE_MAX)
							host_ms = host_ms + 1'b1;
						if (dev_ms < IDLE_MAX)
							dev_ms = dev_ms + 1'b1;
					end
					default: ;
				endcase
			end
			fail_count  <= mismatches;
			outstanding <= due_divisors.size();
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import ubbs_pkg::*;

	// The fourth command code has no meaning; the block must drop such beats
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int IDLE_PCT    = 21;
	localparam int SETTLE      = 64;      // divider latency plus margin
	localparam int HOLD_CYCLES = 1200;    // long receiver stall
	localparam int CYCLE_LIMIT = 400000;

	// Frame templates, position 0 in the low byte; wildcard slots are filled in later
	localparam logic [17:0][7:0] HOST_BYTES = {
		8'hC0, 8'h00, 8'h01, 8'hC2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h0F, 8'h00, 8'hC0
	};
	localparam logic [10:0][7:0] DEV_BYTES = {
		8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01
	};

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	item_t            item         = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_t          result;
	logic             cfg_we       = 1'b0;
	logic [2:0]       cfg_index    = REG_HOST_WINDOW;
	logic [CLK_W-1:0] cfg_data     = '0;

	int fail_count;
	int outstanding;
	int beats_sent   = 0;
	int cycles       = 0;
	bit calm         = 1'b0;   // no idling on either side while set
	bit hold_request = 1'b0;   // asks the receiver for one long stall

	uart_bridge_baud_snooper i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	ubbs_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("uart_bridge_baud_snooper regression: fail");
			$finish;
		end
	end

	// Result side: random backpressure, plus one long stall on request.
	// The stall is counted here so the sender keeps pushing beats meanwhile.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Offer one beat and hold it until taken. Idle gaps drop valid first; a beat that
	// follows straight on keeps valid high, so valid gets only one update per edge.
	task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(0, 99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid     <= 1'b1;
		item.command   <= cmd;
		item.data_byte <= b;
		do
			@(posedge clk);
		while (!item_ready);
		beats_sent++;
	endtask

	// One frame byte: maybe slip in a stray tick, maybe corrupt the byte. A corrupted
	// closing byte leaves the matcher parked, so sometimes follow it with a good one.
	task automatic send_frame_byte(input logic [1:0] side, input logic [7:0] b,
		input int pos, input int last, input int bad_pos);
		logic [7:0] v;
		v = b;
		if (pos == bad_pos)
			v = v ^ 8'($urandom_range(1, 255));
		if ($urandom_range(0, 99) < 2)
			send_beat(CMD_TICK, 8'($urandom));
		send_beat(side, v);
		if (pos == bad_pos && pos == last && $urandom_range(0, 1) == 1)
			send_beat(side, BYTE_END);
	endtask

	// Host baud announcement; bad_pos < 0 gives a clean frame
	task automatic send_host_frame(input logic [BAUD_W-1:0] baud, input int bad_pos);
		logic [7:0] b;
		for (int pos = 0; pos < int'(HOST_LEN); pos++) begin
			if (pos >= int'(HOST_BAUD_B0) && pos <= int'(HOST_BAUD_B2))
				b = baud[8 * (pos - int'(HOST_BAUD_B0)) +: 8];
			else
				b = HOST_BYTES[pos];
			send_frame_byte(CMD_HOST, b, pos, int'(HOST_LAST), bad_pos);
		end
	endtask

	// Device acknowledge carrying the given command code: apply, restore or any other byte
	task automatic send_device_frame(input logic [7:0] code, input int bad_pos);
		logic [7:0] b;
		for (int pos = 0; pos < int'(DEV_LEN); pos++) begin
			b = (pos == int'(DEV_CMD)) ? code : DEV_BYTES[pos];
			send_frame_byte(CMD_DEVICE, b, pos, int'(DEV_LAST), bad_pos);
		end
	endtask

	// Drop valid, wait out every expected result, then let the divider settle
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CLK_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] host_w, input logic [7:0] dev_w,
		input logic [CLK_W-1:0] fast_hz, input logic [CLK_W-1:0] slow_hz,
		input logic [BAUD_W-1:0] dflt);
		write_reg(REG_HOST_WINDOW, CLK_W'(host_w));
		write_reg(REG_DEVICE_WINDOW, CLK_W'(dev_w));
		write_reg(REG_FAST_CLOCK, fast_hz);
		write_reg(REG_SLOW_CLOCK, slow_hz);
		write_reg(REG_DEFAULT_BAUD, CLK_W'(dflt));
		cfg_we <= 1'b0;
	endtask

	// Mix of baud values: zero, low rates that may saturate, common rates, anything
	function automatic logic [BAUD_W-1:0] pick_baud();
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2, 3: return BAUD_W'($urandom_range(1, 5000));
			4, 5, 6: return BAUD_W'($urandom_range(1200, 1000000));
			default: return BAUD_W'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	// Mostly well-formed frames with random content; the rest is broken frames,
	// tick bursts and raw noise on all command codes.
	task automatic run_traffic(input int beats);
		int stop_at;
		int pick;
		int bad;
		logic [7:0] code;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			bad  = ($urandom_range(0, 9) == 0) ? -1 : -2;
			if (pick < 35) begin
				if (bad == -1)
					bad = $urandom_range(0, int'(HOST_LAST));
				send_host_frame(pick_baud(), bad);
			end else if (pick < 75) begin
				if (bad == -1)
					bad = $urandom_range(0, int'(DEV_LAST));
				case ($urandom_range(0, 9))
					0, 1, 2, 3:    code = BYTE_APPLY;
					4, 5, 6, 7:    code = BYTE_RESTORE;
					default:       code = 8'($urandom);
				endcase
				send_device_frame(code, bad);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 8))
					send_beat(CMD_TICK, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 6))
					send_beat(2'($urandom_range(0, 3)), 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: apply right after reset finds a zero pending baud, restore uses
		// the default; then a tick, an unused code and extreme byte values.
		send_device_frame(BYTE_APPLY, -2);
		send_device_frame(BYTE_RESTORE, -2);
		send_beat(CMD_TICK, 8'hFF);
		send_beat(CMD_UNUSED, 8'h00);
		send_beat(CMD_HOST, 8'hFF);
		drain_results();

		run_traffic(250);

		for (int phase = 1; phase <= 5; phase++) begin
			drain_results();
			case (phase)
				// widest windows, fastest clocks, lowest default: divisors clip
				1: load_settings(8'd255, 8'd255, 28'hFFFFFFF, 28'hFFFFFFF, 24'd1);
				// zero windows, slowest clocks, highest default
				2: load_settings(8'd0, 8'd0, 28'd1, 28'd1, 24'hFFFFFF);
				3: load_settings(8'($urandom_range(2, 40)), 8'($urandom_range(2, 40)),
					CLK_W'($urandom_range(1, 28'hFFFFFFF)),
					CLK_W'($urandom_range(1, 28'hFFFFFFF)),
					BAUD_W'($urandom_range(1, 24'hFFFFFF)));
				4: load_settings(8'd255, 8'd200, CLK_W'($urandom_range(1, 28'hFFFFFFF)),
					28'd1, BAUD_W'($urandom_range(1, 5000)));
				default: load_settings(8'($urandom), 8'($urandom),
					CLK_W'($urandom_range(1, 28'hFFFFFFF)),
					CLK_W'($urandom_range(1, 28'hFFFFFFF)),
					BAUD_W'($urandom_range(1, 2000000)));
			endcase

			if (phase == 1) begin
				// Stall the receiver and keep sending restore frames back to back so
				// the result register and divider fill and item_ready drops.
				calm         = 1'b1;
				hold_request = 1'b1;
				repeat (5)
					send_device_frame(BYTE_RESTORE, -2);
				calm = 1'b0;
				drain_results();
			end

			if (phase == 2) begin
				// stretch with no idling on either side
				calm = 1'b1;
				run_traffic(150);
				calm = 1'b0;
				run_traffic(150);
			end else begin
				run_traffic(300);
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("uart_bridge_baud_snooper regression: pass");
		else
			$display("uart_bridge_baud_snooper regression: fail");
		$finish;
	end

endmodule
